FILE: rtl/cpu65_pkg.sv
// Shared types, operation codes and flag constants of the 6502 execute unit.
package cpu65_pkg;

   typedef enum logic [5:0] {
      OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
      OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
      OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
      OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
      OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
      OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
      OP_INX = 6'd24, OP_INY = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27,
      OP_LDY = 6'd28, OP_LSR = 6'd29, OP_ORA = 6'd30, OP_PHA = 6'd31,
      OP_PHP = 6'd32, OP_PLA = 6'd33, OP_PLP = 6'd34, OP_ROL = 6'd35,
      OP_ROR = 6'd36, OP_SBC = 6'd37, OP_SEC = 6'd38, OP_SED = 6'd39,
      OP_SEI = 6'd40, OP_STA = 6'd41, OP_STX = 6'd42, OP_STY = 6'd43,
      OP_TAX = 6'd44, OP_TAY = 6'd45, OP_TSX = 6'd46, OP_TXA = 6'd47,
      OP_TXS = 6'd48, OP_TYA = 6'd49, OP_NOP = 6'd50
   } op_type;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] PUSH_FORCE_MASK = 8'b0011_0000;
   localparam logic [7:0] SP_RESET        = 8'hFD;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] idx_x;
      logic [7:0] idx_y;
      logic [7:0] sp;
      logic [7:0] flags;
   } arch_state_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       data_write;
      logic [7:0] stack_slot;
      logic       branch_taken;
   } exec_result_type;

   // Updates N and Z from a result byte.
   function automatic logic [7:0] set_nz(input logic [7:0] flags, input logic [7:0] value);
      logic [7:0] f;
      f = flags;
      f[FLAG_Z] = (value == 8'h00);
      f[FLAG_N] = value[7];
      return f;
   endfunction

endpackage

FILE: rtl/cpu65_alu.sv
// Combinational execute logic: one operation against the architectural state.
module cpu65_alu (
   input  logic [5:0]                 op,
   input  logic [7:0]                 operand,
   input  logic                       acc_mode,
   input  cpu65_pkg::arch_state_type  cur,
   output cpu65_pkg::arch_state_type  nxt,
   output cpu65_pkg::exec_result_type res
);

   logic [7:0] src;
   logic [7:0] add_b;
   logic [8:0] add_sum;
   logic [7:0] cmp_reg;
   logic [8:0] cmp_diff;
   logic [7:0] rmw_val;
   logic       rmw;
   logic       c_in;

   assign src      = acc_mode ? cur.acc : operand;
   assign c_in     = cur.flags[cpu65_pkg::FLAG_C];
   assign add_b    = (op == cpu65_pkg::OP_SBC) ? ~operand : operand;
   assign add_sum  = {1'b0, cur.acc} + {1'b0, add_b} + {8'h00, c_in};
   assign cmp_reg  = (op == cpu65_pkg::OP_CPX) ? cur.idx_x :
                     (op == cpu65_pkg::OP_CPY) ? cur.idx_y : cur.acc;
   assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

   always_comb begin
      nxt     = cur;
      res     = '0;
      rmw     = 1'b0;
      rmw_val = 8'h00;
      case (op)
         cpu65_pkg::OP_ADC, cpu65_pkg::OP_SBC: begin
            nxt.acc = add_sum[7:0];
            nxt.flags[cpu65_pkg::FLAG_C] = add_sum[8];
            nxt.flags[cpu65_pkg::FLAG_V] =
               (cur.acc[7] ^ add_sum[7]) & (add_b[7] ^ add_sum[7]);
            nxt.flags = cpu65_pkg::set_nz(nxt.flags, add_sum[7:0]);
         end
         cpu65_pkg::OP_AND: begin
            nxt.acc   = cur.acc & operand;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.acc & operand);
         end
         cpu65_pkg::OP_ORA: begin
            nxt.acc   = cur.acc | operand;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.acc | operand);
         end
         cpu65_pkg::OP_EOR: begin
            nxt.acc   = cur.acc ^ operand;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.acc ^ operand);
         end
         cpu65_pkg::OP_ASL: begin
            rmw     = 1'b1;
            rmw_val = {src[6:0], 1'b0};
            nxt.flags[cpu65_pkg::FLAG_C] = src[7];
         end
         cpu65_pkg::OP_ROL: begin
            rmw     = 1'b1;
            rmw_val = {src[6:0], c_in};
            nxt.flags[cpu65_pkg::FLAG_C] = src[7];
         end
         cpu65_pkg::OP_LSR: begin
            rmw     = 1'b1;
            rmw_val = {1'b0, src[7:1]};
            nxt.flags[cpu65_pkg::FLAG_C] = src[0];
         end
         cpu65_pkg::OP_ROR: begin
            rmw     = 1'b1;
            rmw_val = {c_in, src[7:1]};
            nxt.flags[cpu65_pkg::FLAG_C] = src[0];
         end
         cpu65_pkg::OP_INC: begin
            rmw     = 1'b1;
            rmw_val = src + 8'h01;
         end
         cpu65_pkg::OP_DEC: begin
            rmw     = 1'b1;
            rmw_val = src - 8'h01;
         end
         cpu65_pkg::OP_BCC: res.branch_taken = ~cur.flags[cpu65_pkg::FLAG_C];
         cpu65_pkg::OP_BCS: res.branch_taken = cur.flags[cpu65_pkg::FLAG_C];
         cpu65_pkg::OP_BEQ: res.branch_taken = cur.flags[cpu65_pkg::FLAG_Z];
         cpu65_pkg::OP_BNE: res.branch_taken = ~cur.flags[cpu65_pkg::FLAG_Z];
         cpu65_pkg::OP_BMI: res.branch_taken = cur.flags[cpu65_pkg::FLAG_N];
         cpu65_pkg::OP_BPL: res.branch_taken = ~cur.flags[cpu65_pkg::FLAG_N];
         cpu65_pkg::OP_BVS: res.branch_taken = cur.flags[cpu65_pkg::FLAG_V];
         cpu65_pkg::OP_BVC: res.branch_taken = ~cur.flags[cpu65_pkg::FLAG_V];
         cpu65_pkg::OP_BIT: begin
            nxt.flags[cpu65_pkg::FLAG_N] = operand[7];
            nxt.flags[cpu65_pkg::FLAG_V] = operand[6];
            nxt.flags[cpu65_pkg::FLAG_Z] = ((cur.acc & operand) == 8'h00);
         end
         cpu65_pkg::OP_CLC: nxt.flags[cpu65_pkg::FLAG_C] = 1'b0;
         cpu65_pkg::OP_CLD: nxt.flags[cpu65_pkg::FLAG_D] = 1'b0;
         cpu65_pkg::OP_CLI: nxt.flags[cpu65_pkg::FLAG_I] = 1'b0;
         cpu65_pkg::OP_CLV: nxt.flags[cpu65_pkg::FLAG_V] = 1'b0;
         cpu65_pkg::OP_SEC: nxt.flags[cpu65_pkg::FLAG_C] = 1'b1;
         cpu65_pkg::OP_SED: nxt.flags[cpu65_pkg::FLAG_D] = 1'b1;
         cpu65_pkg::OP_SEI: nxt.flags[cpu65_pkg::FLAG_I] = 1'b1;
         cpu65_pkg::OP_CMP, cpu65_pkg::OP_CPX, cpu65_pkg::OP_CPY: begin
            nxt.flags[cpu65_pkg::FLAG_C] = ~cmp_diff[8];
            nxt.flags[cpu65_pkg::FLAG_Z] = (cmp_reg == operand);
            nxt.flags[cpu65_pkg::FLAG_N] = cmp_diff[7];
         end
         cpu65_pkg::OP_DEX: begin
            nxt.idx_x = cur.idx_x - 8'h01;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.idx_x - 8'h01);
         end
         cpu65_pkg::OP_DEY: begin
            nxt.idx_y = cur.idx_y - 8'h01;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.idx_y - 8'h01);
         end
         cpu65_pkg::OP_INX: begin
            nxt.idx_x = cur.idx_x + 8'h01;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.idx_x + 8'h01);
         end
         cpu65_pkg::OP_INY: begin
            nxt.idx_y = cur.idx_y + 8'h01;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.idx_y + 8'h01);
         end
         cpu65_pkg::OP_LDA, cpu65_pkg::OP_PLA: begin
            nxt.acc   = operand;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, operand);
            if (op == cpu65_pkg::OP_PLA) begin
               nxt.sp         = cur.sp + 8'h01;
               res.stack_slot = cur.sp + 8'h01;
            end
         end
         cpu65_pkg::OP_LDX: begin
            nxt.idx_x = operand;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, operand);
         end
         cpu65_pkg::OP_LDY: begin
            nxt.idx_y = operand;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, operand);
         end
         cpu65_pkg::OP_PHA: begin
            res.stack_slot = cur.sp;
            res.data_out   = cur.acc;
            res.data_write = 1'b1;
            nxt.sp         = cur.sp - 8'h01;
         end
         cpu65_pkg::OP_PHP: begin
            res.stack_slot = cur.sp;
            res.data_out   = cur.flags | cpu65_pkg::PUSH_FORCE_MASK;
            res.data_write = 1'b1;
            nxt.sp         = cur.sp - 8'h01;
         end
         cpu65_pkg::OP_PLP: begin
            nxt.sp         = cur.sp + 8'h01;
            res.stack_slot = cur.sp + 8'h01;
            // Bits 4 and 5 are not stored by a pull; they keep their value.
            nxt.flags = (operand & ~cpu65_pkg::PUSH_FORCE_MASK) |
                        (cur.flags & cpu65_pkg::PUSH_FORCE_MASK);
         end
         cpu65_pkg::OP_STA: begin
            res.data_out   = cur.acc;
            res.data_write = 1'b1;
         end
         cpu65_pkg::OP_STX: begin
            res.data_out   = cur.idx_x;
            res.data_write = 1'b1;
         end
         cpu65_pkg::OP_STY: begin
            res.data_out   = cur.idx_y;
            res.data_write = 1'b1;
         end
         cpu65_pkg::OP_TAX: begin
            nxt.idx_x = cur.acc;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.acc);
         end
         cpu65_pkg::OP_TAY: begin
            nxt.idx_y = cur.acc;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.acc);
         end
         cpu65_pkg::OP_TSX: begin
            nxt.idx_x = cur.sp;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.sp);
         end
         cpu65_pkg::OP_TXA: begin
            nxt.acc   = cur.idx_x;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.idx_x);
         end
         cpu65_pkg::OP_TXS: nxt.sp = cur.idx_x;
         cpu65_pkg::OP_TYA: begin
            nxt.acc   = cur.idx_y;
            nxt.flags = cpu65_pkg::set_nz(cur.flags, cur.idx_y);
         end
         default: begin
         end
      endcase

      // Read-modify-write ops land either in A or back in memory.
      if (rmw) begin
         nxt.flags = cpu65_pkg::set_nz(nxt.flags, rmw_val);
         if (acc_mode) begin
            nxt.acc = rmw_val;
         end else begin
            res.data_out   = rmw_val;
            res.data_write = 1'b1;
         end
      end
   end

endmodule

FILE: rtl/cpu_6502_execute_unit.sv
// Top level of the 6502 execute unit: input register, execute logic, result register.
// An accepted item passes through two register stages, the input register and the
// result register, before its result shows on rsp_*.
// Throughput: one item per cycle, set by the combinational 8-bit ALU and the
// architectural register feedback around it; a stalled response holds both stages.
// Reset: synchronous, active high; clears the valid bits, zeroes A, X, Y and P, sets SP to 0xFD.
module cpu_6502_execute_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [5:0] req_op,
   input  logic [7:0] req_operand,
   input  logic       req_acc_mode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_out,
   output logic       rsp_data_write,
   output logic [7:0] rsp_stack_slot,
   output logic       rsp_branch_taken,
   output logic [7:0] rsp_acc_out,
   output logic [7:0] rsp_status_out
);

   // Input stage: holds one accepted item until the execute logic can retire it.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [5:0] in_op_ff;
   logic [7:0] in_operand_ff;
   logic       in_acc_mode_ff;

   // Architectural registers, updated exactly when an item executes.
   cpu65_pkg::arch_state_type state_ff;
   cpu65_pkg::arch_state_type state_in;
   cpu65_pkg::arch_state_type alu_next;
   cpu65_pkg::exec_result_type alu_res;

   // Result register.
   logic       out_valid_ff;
   logic       out_valid_in;
   cpu65_pkg::exec_result_type out_res_ff;
   logic [7:0] out_acc_ff;
   logic [7:0] out_flags_ff;

   logic       out_free;
   logic       execute;
   logic       req_accept;

   cpu65_alu u_alu (
      .op       (in_op_ff),
      .operand  (in_operand_ff),
      .acc_mode (in_acc_mode_ff),
      .cur      (state_ff),
      .nxt      (alu_next),
      .res      (alu_res)
   );

   // The result register can take a new item when empty or being drained this cycle.
   assign out_free   = ~out_valid_ff | ~rsp_stall;
   assign execute    = in_valid_ff & out_free;
   // The input stage refills in the same cycle that its item moves on.
   assign req_stall  = in_valid_ff & ~out_free;
   assign req_accept = req_valid & ~req_stall;

   assign in_valid_in  = req_accept | (in_valid_ff & ~execute);
   assign out_valid_in = execute | (out_valid_ff & rsp_stall);
   assign state_in     = execute ? alu_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.acc   <= 8'h00;
         state_ff.idx_x <= 8'h00;
         state_ff.idx_y <= 8'h00;
         state_ff.sp    <= cpu65_pkg::SP_RESET;
         state_ff.flags <= 8'h00;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff       <= req_op;
         in_operand_ff  <= req_operand;
         in_acc_mode_ff <= req_acc_mode;
      end
      if (execute) begin
         out_res_ff   <= alu_res;
         out_acc_ff   <= alu_next.acc;
         out_flags_ff <= alu_next.flags;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_data_out     = out_res_ff.data_out;
   assign rsp_data_write   = out_res_ff.data_write;
   assign rsp_stack_slot   = out_res_ff.stack_slot;
   assign rsp_branch_taken = out_res_ff.branch_taken;
   assign rsp_acc_out      = out_acc_ff;
   assign rsp_status_out   = out_flags_ff;

endmodule
